### sv/ps2_mouse_cursor_tracker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the PS/2 mouse cursor tracker
// Clocked assertion helpers with reset qualification; they compile to
// nothing when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_CURSOR_TRACKER_ASSERT_SVH
`define PS2_MOUSE_CURSOR_TRACKER_ASSERT_SVH

`ifndef ASSERT_OFF
// The property must hold at every rising edge while out of reset.
`define PMCT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ps2_mouse_cursor_tracker: assertion failed");
// The expression must never be true while out of reset.
`define PMCT_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("ps2_mouse_cursor_tracker: forbidden condition seen");
`else
`define PMCT_ASSERT(lbl, clk, rst_n, prop)
`define PMCT_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

### sv/ps2mct_pkg.sv
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared types and constants of the PS/2 mouse cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  localparam int MOTION_SCALE_DEF = 3;
  localparam int MAX_COLS_DEF     = 256;
  localparam int MAX_ROWS_DEF     = 128;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [8:0]  DEF_COLS     = 9'd80;
  localparam logic [7:0]  DEF_ROWS     = 8'd25;
  localparam logic [10:0] CURSOR_X_RST = 11'd320;
  localparam logic [10:0] CURSOR_Y_RST = 11'd192;

  localparam int CMD_W = 34;

  // Header byte bits of a PS/2 packet.
  localparam int HDR_SYNC_BIT = 3;
  localparam int HDR_XOVF_BIT = 6;
  localparam int HDR_YOVF_BIT = 7;

  // Pointer status word bits.
  localparam int ST_LEFT_BIT   = 5;
  localparam int ST_RIGHT_BIT  = 4;
  localparam int ST_MIDDLE_BIT = 3;
  localparam int ST_REL_BIT    = 16;

  localparam logic [31:0] ABS_FULL_SCALE = 32'd65535;

  typedef enum logic [1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_ABSOLUTE = 2'd1,
    CFG_COLS     = 2'd2,
    CFG_ROWS     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LEFT_NONE    = 2'd0,
    LEFT_PRESS   = 2'd1,
    LEFT_HELD    = 2'd2,
    LEFT_RELEASE = 2'd3
  } left_event_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DX     = 2'd1,
    PH_DY     = 2'd2
  } pkt_phase_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [31:0] ptr_status;
    logic [31:0] ptr_x;
    logic [31:0] ptr_y;
  } in_item_t;

  typedef struct packed {
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic [7:0]  cell_x;
    logic [6:0]  cell_y;
    logic [2:0]  button_bits;
    logic [1:0]  left_event;
    logic        left_click;
    logic        right_click;
  } out_item_t;

  // Effective configuration seen by the front and back parts.
  typedef struct packed {
    logic        enabled;
    logic        absolute;
    logic [10:0] max_x;
    logic [10:0] max_y;
  } cfg_t;

  // One classified update: either a signed motion delta or an absolute
  // product still to be divided by the full scale.
  typedef struct packed {
    logic              is_abs;
    logic [CMD_W-1:0]  val_x;
    logic [CMD_W-1:0]  val_y;
    logic [2:0]        buttons;
  } cmd_t;

endpackage

### sv/ps2mct_fifo.sv
// ----------------------------------------------------------------------------
// ps2mct_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module ps2mct_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = ps2mct_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### sv/ps2mct_front.sv
// ----------------------------------------------------------------------------
// ps2mct_front
// Accepts bytes and samples, assembles PS/2 packets and emits one command
// per packet with no overflow bit set or per pointer sample.
// ----------------------------------------------------------------------------
module ps2mct_front #(
  parameter int MOTION_SCALE = ps2mct_pkg::MOTION_SCALE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ps2mct_pkg::cfg_t     cfg_i,
  input  logic                 accept_i,
  input  ps2mct_pkg::in_item_t item_i,
  output logic                 cmd_push_o,
  output ps2mct_pkg::cmd_t     cmd_o
);

  localparam int MulW = 9 + $clog2(MOTION_SCALE + 1);
  localparam logic signed [MulW-1:0] ScaleS = MulW'(MOTION_SCALE);

  ps2mct_pkg::pkt_phase_e phase_q, phase_d;
  logic [7:0]  header_q, header_d;
  logic [7:0]  dx_q, dx_d;
  logic        byte_ok, sample_ok, ps2_done;
  logic signed [MulW-1:0] dx_mul, dy_mul;
  logic [15:0] abs_x, abs_y;
  logic [26:0] prod_x, prod_y;

  assign byte_ok   = accept_i && cfg_i.enabled && !item_i.kind && !cfg_i.absolute;
  assign sample_ok = accept_i && cfg_i.enabled && item_i.kind && cfg_i.absolute;

  // Next packet phase and byte capture.
  always_comb begin
    phase_d  = phase_q;
    header_d = header_q;
    dx_d     = dx_q;
    if (byte_ok) begin
      unique case (phase_q)
        ps2mct_pkg::PH_HEADER: begin
          if (item_i.data_byte[ps2mct_pkg::HDR_SYNC_BIT]) begin
            header_d = item_i.data_byte;
            phase_d  = ps2mct_pkg::PH_DX;
          end
        end
        ps2mct_pkg::PH_DX: begin
          dx_d    = item_i.data_byte;
          phase_d = ps2mct_pkg::PH_DY;
        end
        default: begin
          phase_d = ps2mct_pkg::PH_HEADER;
        end
      endcase
    end
  end

  assign dx_mul = MulW'($signed(dx_q)) * ScaleS;
  assign dy_mul = MulW'($signed(item_i.data_byte)) * ScaleS;

  // Absolute samples above full scale land on the screen edge.
  assign abs_x  = (item_i.ptr_x >= ps2mct_pkg::ABS_FULL_SCALE) ? 16'hFFFF : item_i.ptr_x[15:0];
  assign abs_y  = (item_i.ptr_y >= ps2mct_pkg::ABS_FULL_SCALE) ? 16'hFFFF : item_i.ptr_y[15:0];
  assign prod_x = 27'(abs_x) * 27'(cfg_i.max_x);
  assign prod_y = 27'(abs_y) * 27'(cfg_i.max_y);

  // Command output.
  always_comb begin
    ps2_done = byte_ok && (phase_q == ps2mct_pkg::PH_DY)
               && header_q[ps2mct_pkg::HDR_SYNC_BIT]
               && !header_q[ps2mct_pkg::HDR_XOVF_BIT]
               && !header_q[ps2mct_pkg::HDR_YOVF_BIT];
    cmd_push_o = ps2_done || sample_ok;
    cmd_o.is_abs  = 1'b0;
    cmd_o.val_x   = ps2mct_pkg::CMD_W'(dx_mul);
    cmd_o.val_y   = -ps2mct_pkg::CMD_W'(dy_mul);
    cmd_o.buttons = header_q[2:0];
    if (item_i.kind) begin
      cmd_o.buttons = {item_i.ptr_status[ps2mct_pkg::ST_MIDDLE_BIT],
                       item_i.ptr_status[ps2mct_pkg::ST_RIGHT_BIT],
                       item_i.ptr_status[ps2mct_pkg::ST_LEFT_BIT]};
      if (item_i.ptr_status[ps2mct_pkg::ST_REL_BIT]) begin
        cmd_o.val_x = ps2mct_pkg::CMD_W'($signed(item_i.ptr_x));
        cmd_o.val_y = -ps2mct_pkg::CMD_W'($signed(item_i.ptr_y));
      end else begin
        cmd_o.is_abs = 1'b1;
        cmd_o.val_x  = ps2mct_pkg::CMD_W'(prod_x);
        cmd_o.val_y  = ps2mct_pkg::CMD_W'(prod_y);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ps2mct_pkg::PH_HEADER;
      header_q <= '0;
      dx_q     <= '0;
    end else begin
      phase_q  <= phase_d;
      header_q <= header_d;
      dx_q     <= dx_d;
    end
  end

endmodule

### sv/ps2mct_back.sv
// ----------------------------------------------------------------------------
// ps2mct_back
// Applies commands to the cursor, clamps it to the screen and tracks the
// buttons, producing one result per command.
// ----------------------------------------------------------------------------
module ps2mct_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ps2mct_pkg::cfg_t      cfg_i,
  input  logic                  cmd_valid_i,
  input  ps2mct_pkg::cmd_t      cmd_i,
  output logic                  cmd_pop_o,
  input  logic                  res_full_i,
  output logic                  res_push_o,
  output ps2mct_pkg::out_item_t res_o
);

  // Divides a product below 65535 * 2048 by 65535: estimate with a shift,
  // then correct once since the remainder stays below twice the divisor.
  function automatic logic [10:0] div_full_scale(input logic [26:0] p);
    logic [10:0] q_est;
    logic [16:0] rem;
    q_est = p[26:16];
    rem   = 17'(p[15:0]) + 17'(q_est);
    return (rem >= 17'(ps2mct_pkg::ABS_FULL_SCALE)) ? q_est + 1'b1 : q_est;
  endfunction

  function automatic logic [10:0] clamp(input logic signed [34:0] v,
                                        input logic [10:0] maxv);
    logic [10:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(35'(maxv))) begin
      r = maxv;
    end else begin
      r = v[10:0];
    end
    return r;
  endfunction

  logic [10:0] cursor_x_q, cursor_x_d, cursor_y_q, cursor_y_d;
  logic [2:0]  held_q;
  logic        left_down_q, left_down_d, dragging_q, dragging_d;
  logic [7:0]  press_col_q, press_col_d, cell_x;
  logic [6:0]  press_row_q, press_row_d, cell_y;
  logic        step;
  logic signed [34:0] cand_x, cand_y;
  ps2mct_pkg::left_event_e left_ev;
  logic        lclick;

  assign step       = cmd_valid_i && !res_full_i;
  assign cmd_pop_o  = step;
  assign res_push_o = step;

  always_comb begin
    if (cmd_i.is_abs) begin
      cand_x = $signed(35'(div_full_scale(cmd_i.val_x[26:0])));
      cand_y = $signed(35'(div_full_scale(cmd_i.val_y[26:0])));
    end else begin
      cand_x = $signed(35'(cursor_x_q)) + 35'($signed(cmd_i.val_x));
      cand_y = $signed(35'(cursor_y_q)) + 35'($signed(cmd_i.val_y));
    end
    cursor_x_d = clamp(cand_x, cfg_i.max_x);
    cursor_y_d = clamp(cand_y, cfg_i.max_y);
    cell_x     = cursor_x_d[10:3];
    cell_y     = cursor_y_d[10:4];
  end

  always_comb begin
    left_down_d = left_down_q;
    dragging_d  = dragging_q;
    press_col_d = press_col_q;
    press_row_d = press_row_q;
    left_ev     = ps2mct_pkg::LEFT_NONE;
    lclick      = 1'b0;
    priority if (cmd_i.buttons[0] && !left_down_q) begin
      left_down_d = 1'b1;
      dragging_d  = 1'b0;
      press_col_d = cell_x;
      press_row_d = cell_y;
      left_ev     = ps2mct_pkg::LEFT_PRESS;
    end else if (cmd_i.buttons[0]) begin
      if (cell_x != press_col_q || cell_y != press_row_q) begin
        dragging_d = 1'b1;
      end
      left_ev = ps2mct_pkg::LEFT_HELD;
    end else if (left_down_q) begin
      left_down_d = 1'b0;
      left_ev     = ps2mct_pkg::LEFT_RELEASE;
      lclick      = !dragging_q;
    end else begin
      left_ev = ps2mct_pkg::LEFT_NONE;
    end
  end

  always_comb begin
    res_o.pixel_x     = cursor_x_d;
    res_o.pixel_y     = cursor_y_d;
    res_o.cell_x      = cell_x;
    res_o.cell_y      = cell_y;
    res_o.button_bits = cmd_i.buttons;
    res_o.left_event  = left_ev;
    res_o.left_click  = lclick;
    res_o.right_click = held_q[1] && !cmd_i.buttons[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q  <= ps2mct_pkg::CURSOR_X_RST;
      cursor_y_q  <= ps2mct_pkg::CURSOR_Y_RST;
      held_q      <= '0;
      left_down_q <= 1'b0;
      dragging_q  <= 1'b0;
      press_col_q <= '0;
      press_row_q <= '0;
    end else if (step) begin
      cursor_x_q  <= cursor_x_d;
      cursor_y_q  <= cursor_y_d;
      held_q      <= cmd_i.buttons;
      left_down_q <= left_down_d;
      dragging_q  <= dragging_d;
      press_col_q <= press_col_d;
      press_row_q <= press_row_d;
    end
  end

endmodule

### sv/ps2_mouse_cursor_tracker.sv
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker
// Assembles PS/2 mouse packets or absolute pointer samples into a clamped
// text-screen cursor with button events.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            beat
//   --------  ---------  -------------------  ---------------------------
//   item      in         push / full          kind, byte, pointer sample
//   result    out        empty / pop          position, buttons, events
//   config    in         cfg_we_i (no wait)   register index and data
//
// One item is accepted per cycle while full is low. The front part turns it
// into a command, and the back part applies one command per cycle while the
// result queue has room, writing each result into the result queue. Full
// rises only when the command queue backs up behind a stalled result queue.
// Reset puts the cursor at (320, 192) and the registers at enabled,
// relative mode, 80 by 25; there is no clearing pass.
//
`include "ps2_mouse_cursor_tracker_assert.svh"

module ps2_mouse_cursor_tracker #(
  parameter int MOTION_SCALE = ps2mct_pkg::MOTION_SCALE_DEF,
  parameter int MAX_COLS     = ps2mct_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS     = ps2mct_pkg::MAX_ROWS_DEF,
  parameter int QUEUE_DEPTH  = ps2mct_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  ps2mct_pkg::in_item_t  item_i,
  output logic                  empty,
  input  logic                  pop,
  output ps2mct_pkg::out_item_t result_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [8:0]            cfg_data_i
);

  // Configuration registers.
  logic       enabled_q, absolute_q;
  logic [8:0] cols_q;
  logic [7:0] rows_q;
  logic [8:0] eff_cols;
  logic [7:0] eff_rows;
  ps2mct_pkg::cfg_t cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= 1'b1;
      absolute_q <= 1'b0;
      cols_q     <= ps2mct_pkg::DEF_COLS;
      rows_q     <= ps2mct_pkg::DEF_ROWS;
    end else if (cfg_we_i) begin
      unique case (ps2mct_pkg::cfg_idx_e'(cfg_index_i))
        ps2mct_pkg::CFG_ENABLE:   enabled_q  <= cfg_data_i[0];
        ps2mct_pkg::CFG_ABSOLUTE: absolute_q <= cfg_data_i[0];
        ps2mct_pkg::CFG_COLS:     cols_q     <= cfg_data_i;
        ps2mct_pkg::CFG_ROWS:     rows_q     <= cfg_data_i[7:0];
      endcase
    end
  end

  // A zero size falls back to the default screen; larger sizes saturate.
  always_comb begin
    if (cols_q == '0) begin
      eff_cols = ps2mct_pkg::DEF_COLS;
    end else if (cols_q > 9'(MAX_COLS)) begin
      eff_cols = 9'(MAX_COLS);
    end else begin
      eff_cols = cols_q;
    end
    if (rows_q == '0) begin
      eff_rows = ps2mct_pkg::DEF_ROWS;
    end else if (rows_q > 8'(MAX_ROWS)) begin
      eff_rows = 8'(MAX_ROWS);
    end else begin
      eff_rows = rows_q;
    end
    cfg.enabled  = enabled_q;
    cfg.absolute = absolute_q;
    cfg.max_x    = 11'({eff_cols, 3'b000} - 12'd1);
    cfg.max_y    = 11'({eff_rows, 4'b0000} - 12'd1);
  end

  // Front part: packet assembly and sample classification.
  logic             accept;
  logic             cmd_push;
  ps2mct_pkg::cmd_t cmd_in, cmd_out;
  logic             cmd_empty, cmd_pop;

  assign accept = push && !full;

  ps2mct_front #(
    .MOTION_SCALE(MOTION_SCALE)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .accept_i  (accept),
    .item_i    (item_i),
    .cmd_push_o(cmd_push),
    .cmd_o     (cmd_in)
  );

  // Command queue between the two parts; its full flag backs up the input.
  ps2mct_fifo #(
    .WIDTH($bits(ps2mct_pkg::cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (full),
    .pop_i  (cmd_pop),
    .data_o (cmd_out),
    .empty_o(cmd_empty)
  );

  // Back part: cursor update and button tracking.
  logic                  res_push, res_full;
  ps2mct_pkg::out_item_t res;

  ps2mct_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_valid_i(!cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  // Result queue: holds finished beats while the consumer stalls.
  ps2mct_fifo #(
    .WIDTH($bits(ps2mct_pkg::out_item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (result_o),
    .empty_o(empty)
  );

  // Terms used by the checks below.
  logic is_release, rclick_held, cell_ok;

  assign is_release  = (result_o.left_event == ps2mct_pkg::LEFT_RELEASE);
  assign rclick_held = result_o.right_click && result_o.button_bits[1];
  assign cell_ok     = (result_o.cell_x == result_o.pixel_x[10:3])
                       && (result_o.cell_y == result_o.pixel_y[10:4]);

  // A left click is only reported together with a left release.
  `PMCT_ASSERT(a_click_on_release, clk_i, rst_ni, !empty && result_o.left_click |-> is_release)
  // A right click means the right button is no longer held.
  `PMCT_ASSERT_NEVER(a_rclick_held, clk_i, rst_ni, !empty && rclick_held)
  // The character cell always follows from the pixel position.
  `PMCT_ASSERT(a_cell_matches, clk_i, rst_ni, !empty |-> cell_ok)

endmodule
